>>> hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
// Used by jsu_decode, jsu_out_stage and json_string_unescape; no dependencies.
package jsu_pkg;

    // Error codes carried with each result beat
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ESCAPE  = 2'd1,
        ERR_HEX     = 2'd2,
        ERR_CONTROL = 2'd3
    } err_code_t;

    // Characters recognized by the decoder
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    // Decoded values of the single-letter escapes
    localparam logic [7:0] VAL_BS = 8'h08;
    localparam logic [7:0] VAL_FF = 8'h0C;
    localparam logic [7:0] VAL_LF = 8'h0A;
    localparam logic [7:0] VAL_CR = 8'h0D;
    localparam logic [7:0] VAL_HT = 8'h09;

    // Plain bytes below this are flagged as control bytes
    localparam logic [7:0] CONTROL_LIMIT = 8'h20;

    // Number of hex digits after \u, minus one (count of the last digit)
    localparam logic [1:0] HEX_LAST = 2'd3;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_end;
        err_code_t  error_code;
    } result_t;

endpackage

>>> hdl/jsu_in_stage.sv
// Input register of the JSON string unescape block.
// Holds one raw byte beat until the decode stage takes it; no package use.
module jsu_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // Accept a new beat when empty or when the held one moves on this cycle
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

>>> hdl/jsu_decode.sv
// Decode stage of the JSON string unescape block: string/escape/\u state
// and the combinational result for one byte. Depends on jsu_pkg.
module jsu_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    output logic             res_valid,
    output jsu_pkg::result_t res
);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_ESCAPE  = 2'd2,
        MODE_UNICODE = 2'd3
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [1:0] hex_cnt_reg, hex_cnt_next;
    logic [3:0] code_reg, code_next;
    logic       hex_err_reg, hex_err_next;

    logic [3:0] digit;
    logic       digit_ok;

    // Hex digit value; a bad digit counts as zero
    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b1;
        case (in_byte) inside
            [8'h30:8'h39]: digit = in_byte[3:0];
            [8'h61:8'h66], [8'h41:8'h46]: digit = in_byte[3:0] + 4'd9;
            default: digit_ok = 1'b0;
        endcase
    end

    // Next state and result for the byte in the input register
    always_comb begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        code_next    = code_reg;
        hex_err_next = hex_err_reg;
        res_valid    = 1'b0;
        res          = '{out_byte: in_byte, string_end: 1'b0,
                         error_code: jsu_pkg::ERR_NONE};
        case (mode_reg)
            MODE_IDLE: begin
                if (in_byte == jsu_pkg::CH_QUOTE) begin
                    mode_next = MODE_STRING;
                end
            end
            MODE_STRING: begin
                if (in_byte == jsu_pkg::CH_BACKSLASH) begin
                    mode_next = MODE_ESCAPE;
                end else if (in_byte == jsu_pkg::CH_QUOTE) begin
                    mode_next      = MODE_IDLE;
                    res_valid      = 1'b1;
                    res.out_byte   = 8'd0;
                    res.string_end = 1'b1;
                end else begin
                    res_valid = 1'b1;
                    if (in_byte < jsu_pkg::CONTROL_LIMIT) begin
                        res.error_code = jsu_pkg::ERR_CONTROL;
                    end
                end
            end
            MODE_ESCAPE: begin
                mode_next = MODE_STRING;
                res_valid = 1'b1;
                case (in_byte)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: begin
                        res.out_byte = in_byte;
                    end
                    jsu_pkg::CH_B: res.out_byte = jsu_pkg::VAL_BS;
                    jsu_pkg::CH_F: res.out_byte = jsu_pkg::VAL_FF;
                    jsu_pkg::CH_N: res.out_byte = jsu_pkg::VAL_LF;
                    jsu_pkg::CH_R: res.out_byte = jsu_pkg::VAL_CR;
                    jsu_pkg::CH_T: res.out_byte = jsu_pkg::VAL_HT;
                    jsu_pkg::CH_U: begin
                        mode_next    = MODE_UNICODE;
                        res_valid    = 1'b0;
                        hex_cnt_next = 2'd0;
                        code_next    = 4'd0;
                        hex_err_next = 1'b0;
                    end
                    default: res.error_code = jsu_pkg::ERR_ESCAPE;
                endcase
            end
            default: begin
                // Only the low 8 bits of the code matter: keep one prior digit
                if (hex_cnt_reg == jsu_pkg::HEX_LAST) begin
                    mode_next    = MODE_STRING;
                    res_valid    = 1'b1;
                    res.out_byte = {code_reg, digit};
                    if (hex_err_reg || !digit_ok) begin
                        res.error_code = jsu_pkg::ERR_HEX;
                    end
                    hex_cnt_next = 2'd0;
                    code_next    = 4'd0;
                    hex_err_next = 1'b0;
                end else begin
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    code_next    = digit;
                    hex_err_next = hex_err_reg || !digit_ok;
                end
            end
        endcase
    end

    // Advance state only when the byte leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            code_reg    <= 4'd0;
            hex_err_reg <= 1'b0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            code_reg    <= code_next;
            hex_err_reg <= hex_err_next;
        end
    end

endmodule

>>> hdl/jsu_out_stage.sv
// Output register of the JSON string unescape block.
// Holds one result beat for the master side. Depends on jsu_pkg.
module jsu_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  jsu_pkg::result_t res,
    output logic             can_take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output jsu_pkg::result_t held
);

    logic             m_valid_reg;
    logic             m_valid_next;
    jsu_pkg::result_t held_reg;

    // Room for a new beat when empty or when the held one leaves now
    assign can_take = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            held_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign held     = held_reg;

endmodule

>>> hdl/json_string_unescape.sv
// Top level of the JSON string unescape block: input register, decode stage,
// output register. Depends on jsu_pkg, jsu_in_stage, jsu_decode, jsu_out_stage.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------
//   s_       | in  | tdata[7:0] = in_byte
//   m_       | out | tdata[7:0] = out_byte; tuser = string_end, error_code
//
// One byte per clock sustained while m_tready is high: a beat waits in the
// input register, is decoded combinationally and lands in the output register
// as it leaves the input register, and its result is then offered on m_.
// Bytes that give no result (idle bytes, opening quote, backslash, u, \u
// digits but the last) still occupy decode. m_tready low while a result is held
// freezes decode; the input register takes one more byte, then s_tready drops.
// aresetn (synchronous) returns the decoder to idle and empties both registers.
module json_string_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser    // [0] string_end, [2:1] error_code
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             can_take;
    logic             fire;
    logic             res_valid;
    jsu_pkg::result_t res;
    jsu_pkg::result_t held;

    // Move the held byte into decode whenever the output side has room
    assign fire = in_valid && can_take;

    jsu_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (can_take),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    jsu_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    jsu_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && res_valid),
        .res      (res),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    assign m_tdata = held.out_byte;
    assign m_tuser = {held.error_code, held.string_end};

`ifndef SYNTHESIS
    // An empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output register");

    // End-of-string beats carry a zero byte and no error
    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
        (m_tdata == 8'd0 && m_tuser[2:1] == jsu_pkg::ERR_NONE))
        else $error("string end beat with data or error");

    // Control-byte errors only flag bytes below space
    a_control_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] == jsu_pkg::ERR_CONTROL) |->
        (m_tdata < jsu_pkg::CONTROL_LIMIT))
        else $error("control error on printable byte");

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");
`endif

endmodule
